/* src/nnt_pkg.sv */
// nearest neighbor tour package: shared types and constants
// no dependencies
package nnt_pkg;
    localparam int unsigned NODE_BITS = 6;
    localparam int unsigned COUNT_BITS = 7;
    typedef logic [NODE_BITS-1:0] t_node;
endpackage

/* src/nnt_if.sv */
// valid/ready stream interface carrying a payload of parameter type
// depends on nothing
interface nnt_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/nnt_cell.sv */
// one city cell: holds a city, computes its rounded distance to a broadcast point
// depends on nnt_pkg
module nnt_cell
    import nnt_pkg::*;
#(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic                         i_start,
    output logic [COORD_BITS:0]          o_dist,
    output logic                         o_done
);
    localparam int unsigned DB = COORD_BITS + 1;
    localparam int unsigned SB = 2 * DB + 1;
    localparam int unsigned RB = DB + 1;
    localparam int unsigned STEPS = (SB + 1) / 2;
    localparam int unsigned CB = $clog2(STEPS + 3);

    logic signed [COORD_BITS-1:0] r_x, r_y;
    logic [DB-1:0] r_dx, r_dy, n_dx, n_dy;
    logic [SB-1:0] r_s, r_rem, n_rem;
    logic [RB-1:0] r_root, n_root;
    logic [CB-1:0] r_cnt;
    logic [2*STEPS-1:0] r_sq;
    logic [SB+1:0] w_trial;
    logic [SB+1:0] w_rem2;
    logic [DB:0] w_r;
    logic signed [COORD_BITS:0] w_ex, w_ey;

    always_comb begin
        w_ex = $signed({r_x[COORD_BITS-1], r_x}) - $signed({i_cx[COORD_BITS-1], i_cx});
        w_ey = $signed({r_y[COORD_BITS-1], r_y}) - $signed({i_cy[COORD_BITS-1], i_cy});
        n_dx = w_ex[COORD_BITS] ? DB'(-w_ex) : DB'(w_ex);
        n_dy = w_ey[COORD_BITS] ? DB'(-w_ey) : DB'(w_ey);
        w_rem2 = {r_rem, r_sq[2*STEPS-1 -: 2]};
        w_trial = {r_root, 2'b01};
        if (w_rem2 >= w_trial) begin
            n_rem = SB'(w_rem2 - w_trial);
            n_root = {r_root[RB-2:0], 1'b1};
        end else begin
            n_rem = SB'(w_rem2);
            n_root = {r_root[RB-2:0], 1'b0};
        end
        w_r = (DB + 1)'(r_root);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_x;
            r_y <= i_y;
        end
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CB'(1);
            r_dx <= n_dx;
            r_dy <= n_dy;
        end else if (r_cnt == CB'(1)) begin
            r_s <= SB'(r_dx * r_dx) + SB'(r_dy * r_dy);
            r_cnt <= CB'(2);
        end else if (r_cnt == CB'(2)) begin
            r_sq <= (2*STEPS)'(r_s);
            r_rem <= '0;
            r_root <= '0;
            r_cnt <= CB'(3);
        end else if (r_cnt >= CB'(3) && r_cnt < CB'(STEPS + 3)) begin
            r_rem <= n_rem;
            r_root <= n_root;
            r_sq <= r_sq << 2;
            r_cnt <= r_cnt + CB'(1);
        end else if (r_cnt == CB'(STEPS + 3)) begin
            r_cnt <= '0;
        end
    end

    assign o_done = (r_cnt == CB'(STEPS + 3));
    assign o_dist = DB'((r_rem > SB'(w_r)) ? w_r + 1'b1 : w_r);
endmodule

/* src/nnt_chain.sv */
// row of city cells and a shift chain that passes candidates to the argmin tail
// depends on nnt_pkg, nnt_cell
module nnt_chain
    import nnt_pkg::*;
#(
    parameter int unsigned MAX_CITIES = 64,
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [NODE_BITS-1:0]         i_load_idx,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic [NODE_BITS-1:0]         i_cur,
    input  logic                         i_start,
    input  logic [MAX_CITIES-1:0]        i_skip,
    output logic                         o_done,
    output logic [NODE_BITS-1:0]         o_best,
    output logic                         o_found
);
    localparam int unsigned DB = COORD_BITS + 1;
    logic signed [COORD_BITS-1:0] r_cx, r_cy;
    logic [DB-1:0] w_d [MAX_CITIES];
    logic [DB-1:0] r_sd [MAX_CITIES];
    logic [MAX_CITIES-1:0] r_sv, w_done;
    logic [NODE_BITS:0] r_pos;
    logic r_run;
    logic [DB-1:0] r_bd;
    logic [NODE_BITS-1:0] r_bi;
    logic r_bf;

    genvar g;
    generate
        for (g = 0; g < MAX_CITIES; g++) begin : g_cell
            logic [DB-1:0] w_dist;
            nnt_cell #(.COORD_BITS(COORD_BITS)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_load (i_load && i_load_idx == NODE_BITS'(g)),
                .i_x    (i_x),
                .i_y    (i_y),
                .i_cx   (r_cx),
                .i_cy   (r_cy),
                .i_start(i_start),
                .o_dist (w_dist),
                .o_done (w_done[g])
            );
            assign w_d[g] = w_dist;
        end
    endgenerate

    // coordinates of every city, kept as a shadow copy; the current city's pair is registered
    logic signed [COORD_BITS-1:0] r_mx [MAX_CITIES];
    logic signed [COORD_BITS-1:0] r_my [MAX_CITIES];
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mx[i_load_idx[$clog2(MAX_CITIES)-1:0]] <= i_x;
            r_my[i_load_idx[$clog2(MAX_CITIES)-1:0]] <= i_y;
        end
        r_cx <= r_mx[i_cur[$clog2(MAX_CITIES)-1:0]];
        r_cy <= r_my[i_cur[$clog2(MAX_CITIES)-1:0]];
    end

    // cells hand results down the row one step per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pos <= '0;
            r_bf <= 1'b0;
        end else if (w_done[0] && !r_run) begin
            r_run <= 1'b1;
            r_pos <= '0;
            r_bf <= 1'b0;
            r_sv <= ~i_skip;
            for (int k = 0; k < MAX_CITIES; k++) r_sd[k] <= w_d[k];
        end else if (r_run) begin
            if (r_sv[0] && (!r_bf || r_sd[0] < r_bd)) begin
                r_bf <= 1'b1;
                r_bd <= r_sd[0];
                r_bi <= r_pos[NODE_BITS-1:0];
            end
            for (int k = 0; k < MAX_CITIES - 1; k++) r_sd[k] <= r_sd[k+1];
            r_sv <= r_sv >> 1;
            r_pos <= r_pos + 1'b1;
            if (r_pos == (NODE_BITS+1)'(MAX_CITIES - 1)) r_run <= 1'b0;
        end
    end

    logic r_fin;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fin <= 1'b0;
        else r_fin <= r_run && r_pos == (NODE_BITS+1)'(MAX_CITIES - 1);
    end
    assign o_done = r_fin;
    assign o_best = r_bi;
    assign o_found = r_bf;
endmodule

/* src/nearest_neighbor_tour.sv */
// nearest neighbor tour top level: load sequencer, hop control, output register
// depends on nnt_pkg, nnt_if, nnt_chain
//
// usage: cities arrive on i_in, one beat each (coord_x, coord_y, final_city).
// a beat with final_city set stores its city and starts the tour build
// from start node (i_cfg_we / i_cfg_data, write only while idle).
// results leave on o_out as node_index, last_of_tour, error beats; the first
// is the start node, the last carries last_of_tour.
// a start node not below the loaded count gives one error beat.
// loading accepts one city per cycle while input ready is high; the first
// result is valid the cycle after the final city. each further hop runs
// the distance computation in every cell (a bit-serial square root), a
// pass down the cell row for the minimum, and the hop, wait and emit
// control states.
// input ready is low while a tour is built or emitted.
// a stalled receiver holds the output register and pauses the hop sequence.
// reset clears the count, visited bits, start node and control; coordinates
// are left as they are.
module nearest_neighbor_tour
    import nnt_pkg::*;
#(
    parameter int unsigned MAX_CITIES = 64,
    parameter int unsigned COORD_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [NODE_BITS-1:0] i_cfg_data,
    nnt_if.sink   i_in,
    nnt_if.source o_out
);
    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_HOP  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [NODE_BITS-1:0] r_start, r_cur;
    logic [COUNT_BITS-1:0] r_count, r_emit;
    logic [MAX_CITIES-1:0] r_vis;
    logic r_ov;
    logic [NODE_BITS-1:0] r_on;
    logic r_ol, r_oe, r_hop;
    logic w_acc, w_done, w_found;
    logic [NODE_BITS-1:0] w_best;
    logic [COUNT_BITS-1:0] w_n;

    assign i_in.ready = (r_state == S_LOAD) && !r_ov;
    assign w_acc = i_in.valid && i_in.ready;
    assign o_out.valid = r_ov;
    assign o_out.data = {r_on, r_ol, r_oe};
    assign w_n = (r_count < COUNT_BITS'(MAX_CITIES)) ? r_count + 1'b1 : r_count;

    nnt_chain #(.MAX_CITIES(MAX_CITIES), .COORD_BITS(COORD_BITS)) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_acc && r_count < COUNT_BITS'(MAX_CITIES)),
        .i_load_idx(r_count[NODE_BITS-1:0]),
        .i_x       (i_in.data[2*COORD_BITS:COORD_BITS+1]),
        .i_y       (i_in.data[COORD_BITS:1]),
        .i_cur     (r_cur),
        .i_start   (r_hop),
        .i_skip    (r_vis),
        .o_done    (w_done),
        .o_best    (w_best),
        .o_found   (w_found)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_start <= '0;
            r_count <= '0;
            r_emit <= '0;
            r_vis <= '0;
            r_ov <= 1'b0;
            r_hop <= 1'b0;
            r_cur <= '0;
        end else begin
            r_hop <= 1'b0;
            if (i_cfg_we) r_start <= i_cfg_data;
            if (r_ov && o_out.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        r_count <= w_n;
                        if (i_in.data[0]) begin
                            r_ov <= 1'b1;
                            r_oe <= 1'b0;
                            if (COUNT_BITS'(r_start) >= w_n) begin
                                r_on <= '0;
                                r_ol <= 1'b1;
                                r_oe <= 1'b1;
                                r_count <= '0;
                            end else begin
                                r_on <= r_start;
                                r_cur <= r_start;
                                r_ol <= (w_n == COUNT_BITS'(1));
                                r_vis <= MAX_CITIES'(1) << r_start;
                                r_emit <= COUNT_BITS'(1);
                                if (w_n == COUNT_BITS'(1)) r_count <= '0;
                                else begin
                                    r_state <= S_HOP;
                                end
                            end
                        end
                    end
                end
                S_HOP: begin
                    r_vis <= r_vis | ~((MAX_CITIES'(1) << r_count) - 1'b1);
                    r_hop <= 1'b1;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_done) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov <= 1'b1;
                        r_on <= w_best;
                        r_oe <= 1'b0;
                        r_ol <= (r_emit + 1'b1 == r_count);
                        r_cur <= w_best;
                        r_vis <= r_vis | (MAX_CITIES'(1) << w_best);
                        r_emit <= r_emit + 1'b1;
                        if (r_emit + 1'b1 == r_count) begin
                            r_state <= S_LOAD;
                            r_count <= '0;
                            r_vis <= '0;
                        end else begin
                            r_state <= S_HOP;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> w_found) else $error("no candidate found");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !i_in.ready) else $error("ready during build");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_BITS'(MAX_CITIES)) else $error("count overflow");
endmodule
